### rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared types and codes for the compacting array store
// Command and status codes, plus the control word that is broadcast to
// every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  // Command codes.
  localparam logic [2:0] CMD_APPEND      = 3'd0;
  localparam logic [2:0] CMD_READ_AT     = 3'd1;
  localparam logic [2:0] CMD_READ_LAST   = 3'd2;
  localparam logic [2:0] CMD_DELETE_AT   = 3'd3;
  localparam logic [2:0] CMD_DELETE_LAST = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Width of a stored word.
  localparam int unsigned WORD_W = 32;

  // Cells read at a time by one first-level select group.
  localparam int unsigned GROUP_SIZE = 8;

  // Operation flags broadcast to every cell; at most one is set.
  typedef struct packed {
    logic load;    // cell at the target position takes the new word
    logic remove;  // cells at or above the target take the upper neighbor
    logic read;    // cell at the target position drives its word
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/compacting_array_store_unit.sv
// ----------------------------------------------------------------------------
// compacting_array_store_unit: order-keeping array of words with delete-shift
// A row of cells holds the entries packed from position 0; a delete moves
// every later entry down one place at once.
// Pipeline: an accepted command loads the group word registers of the select
// tree and the s1 stage; from s1, read_data, count and status are registered
// together with done (one result per accepted command). busy is high while s1
// holds a command, so a new command is not taken before the last one's result.
// Reset: rst clears the fill count and the pipeline flags; stored words keep
// whatever they held and are never read before being written.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_array_store_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command,
  input  wire logic [5:0]         index,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      read_data,
  output logic [6:0]              count,
  output logic [1:0]              status
);

  localparam int unsigned POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = CNT_W + 6;
  localparam int unsigned NUM_GROUPS =
    (CAPACITY + cas_pkg::GROUP_SIZE - 1) / cas_pkg::GROUP_SIZE;

  // Control state.
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             s1_valid;
  logic [CNT_W-1:0] s1_count;
  logic [1:0]       s1_status;
  logic [cas_pkg::WORD_W-1:0] grp_word      [NUM_GROUPS];
  logic [cas_pkg::WORD_W-1:0] grp_word_next [NUM_GROUPS];
  logic [cas_pkg::WORD_W-1:0] final_word;

  // Command decode.
  logic                accept;
  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    fill_ext;
  logic [CNT_W-1:0]    fill_minus_one;
  logic                idx_ok;
  logic                not_empty;
  logic                not_full;
  logic [POS_W-1:0]    target;
  logic [1:0]          status_next;
  cas_pkg::cell_ctrl_t ctrl;

  // Cell row.
  logic [cas_pkg::WORD_W-1:0] cell_word [CAPACITY];
  logic [cas_pkg::WORD_W-1:0] cell_rd   [CAPACITY];

  assign accept         = start && !busy;
  assign busy           = s1_valid;
  assign idx_ext        = CMP_W'(index);
  assign fill_ext       = CMP_W'(fill_count);
  assign fill_minus_one = fill_count - CNT_W'(1);
  assign idx_ok         = (idx_ext < fill_ext);
  assign not_empty      = (fill_count != '0);
  assign not_full       = (fill_ext < CMP_W'(CAPACITY));

  // Decode the command into cell control, a target position and a status.
  always_comb begin
    ctrl            = '0;
    target          = '0;
    status_next     = cas_pkg::ST_OK;
    fill_count_next = fill_count;
    unique case (command)
      cas_pkg::CMD_APPEND: begin
        target = POS_W'(fill_count);
        if (not_full) begin
          ctrl.load       = accept;
          fill_count_next = fill_count + CNT_W'(1);
        end else begin
          status_next = cas_pkg::ST_FULL;
        end
      end
      cas_pkg::CMD_READ_AT: begin
        target = POS_W'(index);
        if (idx_ok) begin
          ctrl.read = accept;
        end else begin
          status_next = cas_pkg::ST_RANGE;
        end
      end
      cas_pkg::CMD_READ_LAST: begin
        target = POS_W'(fill_minus_one);
        if (not_empty) begin
          ctrl.read = accept;
        end else begin
          status_next = cas_pkg::ST_RANGE;
        end
      end
      cas_pkg::CMD_DELETE_AT: begin
        target = POS_W'(index);
        if (idx_ok) begin
          ctrl.remove     = accept;
          fill_count_next = fill_minus_one;
        end else begin
          status_next = cas_pkg::ST_RANGE;
        end
      end
      cas_pkg::CMD_DELETE_LAST: begin
        target = POS_W'(fill_minus_one);
        if (not_empty) begin
          ctrl.remove     = accept;
          fill_count_next = fill_minus_one;
        end else begin
          status_next = cas_pkg::ST_RANGE;
        end
      end
      default: begin
        // Unused codes leave everything as it is.
      end
    endcase
  end

  // The row of storage cells; the top cell shifts in a don't-care word.
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    logic [cas_pkg::WORD_W-1:0] upper;
    if (c + 1 < CAPACITY) begin : g_mid
      assign upper = cell_word[c + 1];
    end else begin : g_top
      assign upper = '0;
    end
    cas_cell #(
      .POS_W(POS_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .my_pos    (POS_W'(c)),
      .target    (target),
      .load_word (value),
      .upper_word(upper),
      .word      (cell_word[c]),
      .read_word (cell_rd[c])
    );
  end

  // First select level: OR the read contributions of each group of cells.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_word_next[g] = '0;
      for (int m = 0; m < cas_pkg::GROUP_SIZE; m++) begin
        if (g * cas_pkg::GROUP_SIZE + m < CAPACITY) begin
          grp_word_next[g] = grp_word_next[g] | cell_rd[g * cas_pkg::GROUP_SIZE + m];
        end
      end
    end
  end

  // Second select level: OR the registered group words.
  always_comb begin
    final_word = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      final_word = final_word | grp_word[g];
    end
  end

  // Fill count and pipeline flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      s1_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
      end
      s1_valid <= accept;
      done     <= s1_valid;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_count  <= fill_count_next;
      s1_status <= status_next;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_word[g] <= grp_word_next[g];
      end
    end
    if (s1_valid) begin
      read_data <= final_word;
      count     <= 7'(s1_count);
      status    <= s1_status;
    end
  end

  // Checks on the block's own control.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("result word did not follow an accepted command");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(fill_count) <= CMP_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == cas_pkg::ST_FULL) |-> (CMP_W'(fill_count) == CMP_W'(CAPACITY)))
    else $error("full status reported while the store has room");

endmodule

`default_nettype wire

### rtl/cas_cell.sv
// ----------------------------------------------------------------------------
// cas_cell: one storage position of the compacting array store
// Holds one word. Loads a new word on append, takes its upper neighbor's
// word when a delete closes the gap, and drives its word on a read hit.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_cell #(
  parameter int unsigned POS_W = 6
) (
  input  wire logic                        clk,
  input  wire cas_pkg::cell_ctrl_t         ctrl,
  input  wire logic [POS_W-1:0]            my_pos,
  input  wire logic [POS_W-1:0]            target,
  input  wire logic [cas_pkg::WORD_W-1:0]  load_word,
  input  wire logic [cas_pkg::WORD_W-1:0]  upper_word,
  output logic      [cas_pkg::WORD_W-1:0]  word,
  output logic      [cas_pkg::WORD_W-1:0]  read_word
);

  logic hit;
  logic above;

  assign hit   = (my_pos == target);
  assign above = (my_pos >= target);

  // Stored word: append writes at the end, delete shifts the tail down.
  always_ff @(posedge clk) begin
    if (ctrl.load && hit) begin
      word <= load_word;
    end else if (ctrl.remove && above) begin
      word <= upper_word;
    end
  end

  // Read contribution: zero unless this cell is the one being read.
  assign read_word = (ctrl.read && hit) ? word : '0;

endmodule

`default_nettype wire
